FILE: sv/clst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the circular list store.
// No dependencies; used by circular_list_store_top.
package clst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 16;
    localparam int ENTRIES_W    = 5;
    localparam int DIV_CNT_W    = $clog2(POS_W);

    // request codes
    localparam logic [2:0] REQ_INS_HEAD = 3'd0;
    localparam logic [2:0] REQ_INS_TAIL = 3'd1;
    localparam logic [2:0] REQ_DEL_HEAD = 3'd2;
    localparam logic [2:0] REQ_DEL_POS  = 3'd3;
    localparam logic [2:0] REQ_LIST     = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]                req_type;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic [1:0]                status;
        logic [ENTRIES_W-1:0]      entries;
        logic                      last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_DREAD,
        S_DTAKE,
        S_SREAD,
        S_SWRITE,
        S_LREAD,
        S_LEMIT,
        S_RESULT
    } state_t;

endpackage

FILE: sv/circular_list_store_top.sv
`timescale 1ns / 1ps
// Circular list store: ring memory with head index and fill count under a sequencer.
// Depends on clst_pkg.
//
// One request is worked at a time; req_stall stays high until its last result beat is
// loaded into the output register. Delete at a position first reduces the position
// modulo the count with a one-bit-per-cycle compare/subtract unit; a zero residue counts
// as the count. A residue selecting the head advances the head index; any other closes
// the gap by moving each later entry one place down, a read and then a write per entry
// through the ring memory. List all reads each listed value from the memory with a
// registered read. The output register lets a new request be taken while the previous
// result beat waits on rsp_stall.
module circular_list_store_top #(
    parameter int CAPACITY = clst_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  clst_pkg::in_item_t   req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output clst_pkg::out_item_t  rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    clst_pkg::state_t                   state_reg, state_next;
    clst_pkg::in_item_t                 req_reg, req_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [IDX_W-1:0]                   head_reg, head_next;
    logic [IDX_W-1:0]                   k_reg, k_next;
    logic [CNT_W-1:0]                   rem_reg, rem_next;
    logic [clst_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [clst_pkg::DIV_CNT_W-1:0]     bit_reg, bit_next;
    logic signed [clst_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic [1:0]                         res_status_reg, res_status_next;
    logic                               rsp_valid_reg, rsp_valid_next;
    clst_pkg::out_item_t                rsp_reg, rsp_next;

    logic signed [clst_pkg::VALUE_W-1:0] mem [CAPACITY];
    logic signed [clst_pkg::VALUE_W-1:0] rd_data_reg;
    logic                               mem_we, mem_re;
    logic [IDX_W-1:0]                   mem_waddr, mem_raddr;
    logic signed [clst_pkg::VALUE_W-1:0] mem_wdata;

    logic [IDX_W-1:0]                   slot_arg, slot_addr, head_dec, head_inc;
    logic [IDX_W:0]                     slot_sum;
    logic [CNT_W:0]                     rem_shift;
    logic [CNT_W-1:0]                   rem_new, k_plus;
    logic [IDX_W-1:0]                   k_from_rem;
    logic                               rsp_free, shift_more, div_done, list_last;

    assign req_stall = (state_reg != clst_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // ring slot of list position k: (head + k) mod CAPACITY
    always_comb
    begin
        unique case (state_reg)
            clst_pkg::S_DISPATCH: slot_arg = count_reg[IDX_W-1:0];
            clst_pkg::S_SREAD:    slot_arg = k_reg + IDX_W'(1);
            default:              slot_arg = k_reg;
        endcase
    end

    assign slot_sum  = {1'b0, head_reg} + {1'b0, slot_arg};
    assign slot_addr = (slot_sum >= (IDX_W + 1)'(CAPACITY)) ?
                       IDX_W'(slot_sum - (IDX_W + 1)'(CAPACITY)) : slot_sum[IDX_W-1:0];
    assign head_dec  = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - IDX_W'(1);
    assign head_inc  = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + IDX_W'(1);

    // shared compare/subtract step of the position-modulo-count unit
    assign rem_shift  = {rem_reg, pos_reg[clst_pkg::POS_W-1]};
    assign rem_new    = (rem_shift >= {1'b0, count_reg}) ?
                        CNT_W'(rem_shift - {1'b0, count_reg}) : rem_shift[CNT_W-1:0];
    // residue zero means the last element
    assign k_from_rem = (rem_new == '0) ? IDX_W'(count_reg - CNT_W'(1))
                                        : IDX_W'(rem_new - CNT_W'(1));
    assign div_done   = (bit_reg == clst_pkg::DIV_CNT_W'(clst_pkg::POS_W - 1));

    assign k_plus     = CNT_W'(k_reg) + CNT_W'(1);
    assign shift_more = (k_plus < count_reg);
    assign list_last  = (k_plus == count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clst_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = clst_pkg::S_DISPATCH;
            end
            clst_pkg::S_DISPATCH:
            begin
                unique case (req_reg.req_type) inside
                    clst_pkg::REQ_DEL_HEAD:
                        state_next = (count_reg == '0) ? clst_pkg::S_RESULT : clst_pkg::S_DREAD;
                    clst_pkg::REQ_DEL_POS:
                        state_next = (count_reg == '0) ? clst_pkg::S_RESULT : clst_pkg::S_DIV;
                    clst_pkg::REQ_LIST:
                        state_next = (count_reg == '0) ? clst_pkg::S_RESULT : clst_pkg::S_LREAD;
                    default:
                        state_next = clst_pkg::S_RESULT;
                endcase
            end
            clst_pkg::S_DIV:
            begin
                if (div_done)
                    state_next = clst_pkg::S_DREAD;
            end
            clst_pkg::S_DREAD:
                state_next = clst_pkg::S_DTAKE;
            clst_pkg::S_DTAKE:
                state_next = (k_reg == '0) ? clst_pkg::S_RESULT : clst_pkg::S_SREAD;
            clst_pkg::S_SREAD:
                state_next = shift_more ? clst_pkg::S_SWRITE : clst_pkg::S_RESULT;
            clst_pkg::S_SWRITE:
                state_next = clst_pkg::S_SREAD;
            clst_pkg::S_LREAD:
                state_next = clst_pkg::S_LEMIT;
            clst_pkg::S_LEMIT:
            begin
                if (rsp_free)
                    state_next = list_last ? clst_pkg::S_IDLE : clst_pkg::S_LREAD;
            end
            clst_pkg::S_RESULT:
            begin
                if (rsp_free)
                    state_next = clst_pkg::S_IDLE;
            end
            default:
                state_next = clst_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next        = req_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        k_next          = k_reg;
        rem_next        = rem_reg;
        pos_next        = pos_reg;
        bit_next        = bit_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = slot_addr;
        mem_raddr       = slot_addr;
        mem_wdata       = rd_data_reg;

        unique case (state_reg)
            clst_pkg::S_IDLE:
            begin
                if (req_valid)
                    req_next = req;
            end
            clst_pkg::S_DISPATCH:
            begin
                res_value_next  = '0;
                res_status_next = clst_pkg::STAT_OK;
                unique case (req_reg.req_type) inside
                    clst_pkg::REQ_INS_HEAD, clst_pkg::REQ_INS_TAIL:
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                            res_status_next = clst_pkg::STAT_FULL;
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_wdata  = req_reg.value;
                            count_next = count_reg + CNT_W'(1);
                            if (req_reg.req_type == clst_pkg::REQ_INS_HEAD)
                            begin
                                head_next = head_dec;
                                mem_waddr = head_dec;
                            end
                        end
                    end
                    clst_pkg::REQ_DEL_HEAD, clst_pkg::REQ_DEL_POS, clst_pkg::REQ_LIST:
                    begin
                        if (count_reg == '0)
                            res_status_next = clst_pkg::STAT_EMPTY;
                        k_next   = '0;
                        rem_next = '0;
                        pos_next = req_reg.position;
                        bit_next = '0;
                    end
                    default:
                        res_status_next = clst_pkg::STAT_OK;
                endcase
            end
            clst_pkg::S_DIV:
            begin
                rem_next = rem_new;
                pos_next = pos_reg << 1;
                bit_next = bit_reg + clst_pkg::DIV_CNT_W'(1);
                if (div_done)
                    k_next = k_from_rem;
            end
            clst_pkg::S_DREAD:
                mem_re = 1'b1;
            clst_pkg::S_DTAKE:
            begin
                res_value_next = rd_data_reg;
                if (k_reg == '0)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            clst_pkg::S_SREAD:
            begin
                // fetch the next entry, or finish once the gap reaches the tail
                if (shift_more)
                    mem_re = 1'b1;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            clst_pkg::S_SWRITE:
            begin
                mem_we = 1'b1;
                k_next = k_reg + IDX_W'(1);
            end
            clst_pkg::S_LREAD:
                mem_re = 1'b1;
            clst_pkg::S_LEMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.item_value = rd_data_reg;
                    rsp_next.status     = clst_pkg::STAT_OK;
                    rsp_next.entries    = clst_pkg::ENTRIES_W'(count_reg);
                    rsp_next.last       = list_last;
                    k_next              = k_reg + IDX_W'(1);
                end
            end
            clst_pkg::S_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.item_value = res_value_reg;
                    rsp_next.status     = res_status_reg;
                    rsp_next.entries    = clst_pkg::ENTRIES_W'(count_reg);
                    rsp_next.last       = 1'b1;
                end
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clst_pkg::S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        k_reg          <= k_next;
        rem_reg        <= rem_next;
        pos_reg        <= pos_next;
        bit_reg        <= bit_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

    // ring memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == clst_pkg::S_RESULT))
        else $error("fill count changed outside the end of a request");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == clst_pkg::S_SWRITE) |-> (k_plus < count_reg))
        else $error("gap close moved past the tail");

endmodule

FILE: tb/tb_circular_list_store_top.sv
`timescale 1ns / 1ps
// Self-checking bench for circular_list_store_top: queued requests, random idling on both sides.
// Holds its own ring-list predictor and compares every response beat in order.
// Depends on clst_pkg and circular_list_store_top.
module tb_circular_list_store_top;

    localparam int CAP          = clst_pkg::CAPACITY_DEF;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
    localparam logic [2:0] REQ_BAD_LAST  = 3'd7;

    localparam logic signed [clst_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [clst_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    clst_pkg::in_item_t  req       = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    clst_pkg::out_item_t rsp;

    clst_pkg::in_item_t  pending_reqs[$];
    clst_pkg::out_item_t expected_rsps[$];

    // predictor state
    logic [clst_pkg::VALUE_W-1:0] ring[CAP];
    int ring_head = 0;
    int ring_fill = 0;

    logic req_taken    = 1'b0;
    int   req_gap      = 0;
    int   rsp_gap      = 0;
    int   req_idle_pct = 0;
    int   rsp_idle_pct = 0;
    int   quiet_cycles = 0;
    int   fail_count   = 0;

    circular_list_store_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    function automatic void push_rsp(logic [clst_pkg::VALUE_W-1:0] item, logic [1:0] stat,
                                     logic fin);
        clst_pkg::out_item_t o;
        o.item_value = item;
        o.status     = stat;
        o.entries    = clst_pkg::ENTRIES_W'(ring_fill);
        o.last       = fin;
        expected_rsps.push_back(o);
    endfunction

    function automatic void list_request(clst_pkg::in_item_t r);
        int pick;
        int k;
        logic [clst_pkg::VALUE_W-1:0] taken;
        case (r.req_type)
            clst_pkg::REQ_INS_HEAD, clst_pkg::REQ_INS_TAIL:
            begin
                if (ring_fill >= CAP)
                begin
                    push_rsp('0, clst_pkg::STAT_FULL, 1'b1);
                end
                else
                begin
                    if (r.req_type == clst_pkg::REQ_INS_HEAD)
                    begin
                        ring_head       = (ring_head + CAP - 1) % CAP;
                        ring[ring_head] = r.value;
                    end
                    else
                    begin
                        ring[(ring_head + ring_fill) % CAP] = r.value;
                    end
                    ring_fill++;
                    push_rsp('0, clst_pkg::STAT_OK, 1'b1);
                end
            end
            clst_pkg::REQ_DEL_HEAD, clst_pkg::REQ_DEL_POS:
            begin
                if (ring_fill == 0)
                begin
                    push_rsp('0, clst_pkg::STAT_EMPTY, 1'b1);
                end
                else
                begin
                    pick = 1;
                    if (r.req_type == clst_pkg::REQ_DEL_POS)
                    begin
                        // a zero residue wraps to the tail
                        pick = int'(r.position) % ring_fill;
                        if (pick == 0)
                            pick = ring_fill;
                    end
                    taken = ring[(ring_head + pick - 1) % CAP];
                    if (pick == 1)
                        ring_head = (ring_head + 1) % CAP;
                    else
                        for (k = pick - 1; k + 1 < ring_fill; k++)
                            ring[(ring_head + k) % CAP] = ring[(ring_head + k + 1) % CAP];
                    ring_fill--;
                    push_rsp(taken, clst_pkg::STAT_OK, 1'b1);
                end
            end
            clst_pkg::REQ_LIST:
            begin
                if (ring_fill == 0)
                    push_rsp('0, clst_pkg::STAT_EMPTY, 1'b1);
                else
                    for (k = 0; k < ring_fill; k++)
                        push_rsp(ring[(ring_head + k) % CAP], clst_pkg::STAT_OK,
                                 k + 1 == ring_fill);
            end
            default:
            begin
                push_rsp('0, clst_pkg::STAT_OK, 1'b1);
            end
        endcase
    endfunction

    // request side: hold a stalled beat, otherwise idle or take the next queued item
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_taken)
        begin
            if (req_gap > 0)
            begin
                req_gap = req_gap - 1;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0 && $urandom_range(99) < req_idle_pct)
            begin
                req_gap = $urandom_range(0, 8);
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // response side stall bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else if (rsp_gap > 0)
        begin
            rsp_gap = rsp_gap - 1;
            rsp_stall <= 1'b1;
        end
        else if ($urandom_range(99) < rsp_idle_pct)
        begin
            rsp_gap = $urandom_range(0, 8);
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // check response beats, then predict from the request beat of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= req_valid && !req_stall;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response beat: item_value %0d status %0d entries %0d",
                           rsp.item_value, rsp.status, rsp.entries);
                    fail_count++;
                end
                else
                begin
                    clst_pkg::out_item_t want;
                    want = expected_rsps.pop_front();
                    if (rsp.item_value !== want.item_value)
                    begin
                        $error("item_value: expected %0d, got %0d", want.item_value,
                               rsp.item_value);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.entries !== want.entries)
                    begin
                        $error("entries: expected %0d, got %0d", want.entries, rsp.entries);
                        fail_count++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, rsp.last);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                list_request(req);

            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("[circular_list_store_top] ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic void queue_req(logic [2:0] kind,
                                      logic signed [clst_pkg::VALUE_W-1:0] val,
                                      logic [clst_pkg::POS_W-1:0] pos);
        clst_pkg::in_item_t r;
        r.req_type = kind;
        r.value    = val;
        r.position = pos;
        pending_reqs.push_back(r);
    endfunction

    // grow_pct steers the fill level: share of inserts among inserts and deletes
    task automatic queue_random(int count, int grow_pct);
        int n;
        int roll;
        logic [2:0] kind;
        logic signed [clst_pkg::VALUE_W-1:0] val;
        logic [clst_pkg::POS_W-1:0] pos;
        for (n = 0; n < count; n++)
        begin
            val  = $urandom;
            roll = $urandom_range(99);
            if (roll < 4)
                val = VAL_MAX;
            else if (roll < 8)
                val = VAL_MIN;
            pos = ($urandom_range(99) < 50) ? clst_pkg::POS_W'($urandom_range(0, 20))
                                            : clst_pkg::POS_W'($urandom);
            roll = $urandom_range(99);
            if (roll < 4)
                kind = 3'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST));
            else if (roll < 14)
                kind = clst_pkg::REQ_LIST;
            else if ($urandom_range(99) < grow_pct)
                kind = $urandom_range(1) ? clst_pkg::REQ_INS_TAIL : clst_pkg::REQ_INS_HEAD;
            else
                kind = ($urandom_range(2) == 0) ? clst_pkg::REQ_DEL_HEAD
                                                : clst_pkg::REQ_DEL_POS;
            queue_req(kind, val, pos);
        end
    endtask

    task automatic run_phase(int req_pct, int rsp_pct);
        req_idle_pct = req_pct;
        rsp_idle_pct = rsp_pct;
        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list, unknown codes, fill to full, overflow, list, each delete flavor
        queue_req(clst_pkg::REQ_LIST, VAL_MAX, '0);
        queue_req(clst_pkg::REQ_DEL_HEAD, '0, '0);
        queue_req(clst_pkg::REQ_DEL_POS, '0, 16'hFFFF);
        queue_req(REQ_BAD_FIRST, VAL_MIN, 16'hFFFF);
        queue_req(REQ_BAD_LAST, VAL_MAX, 16'h0001);
        for (n = 0; n < CAP; n++)
            queue_req((n % 2) ? clst_pkg::REQ_INS_TAIL : clst_pkg::REQ_INS_HEAD,
                      (n == 0) ? VAL_MAX : (n == 1) ? VAL_MIN : (n == 2) ? -1 : n,
                      '0);
        queue_req(clst_pkg::REQ_INS_TAIL, 32'sd77, '0);
        queue_req(clst_pkg::REQ_LIST, '0, '0);
        queue_req(clst_pkg::REQ_DEL_POS, '0, 16'd0);
        queue_req(clst_pkg::REQ_DEL_POS, '0, 16'd16);
        queue_req(clst_pkg::REQ_DEL_POS, '0, 16'd5);
        queue_req(clst_pkg::REQ_DEL_HEAD, '0, '0);
        run_phase(0, 0);

        queue_random(120, 70);
        run_phase(30, 30);
        queue_random(60, 50);
        run_phase(0, 0);
        queue_random(120, 30);
        run_phase(20, 50);
        queue_random(90, 85);
        run_phase(15, 15);
        queue_random(80, 50);
        run_phase(0, 0);

        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[circular_list_store_top] OK");
        else
            $display("[circular_list_store_top] ERROR");
        $finish;
    end

endmodule
